@@ rtl/core/ring_queue_with_prefix_reverse_core_macros.svh @@
// assertion helpers for the ring queue checker
`ifndef RING_QUEUE_WITH_PREFIX_REVERSE_CORE_MACROS_SVH
`define RING_QUEUE_WITH_PREFIX_REVERSE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RQPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RQPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rqpr_pkg.sv @@
package rqpr_pkg;

    localparam int DATA_W    = 32;
    localparam int LEN_W     = 7;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int FILL_W    = 7;
    localparam int CAP_W     = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int DEPTH_DEF = 64;
    localparam int CAP_RESET = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_REV  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_DONE
    } state_t;

endpackage

@@ rtl/core/ring_queue_with_prefix_reverse_core.sv @@
// Circular queue of signed 32-bit words in a single-port-write RAM, with a
// usable capacity set by cfg_wdata (0 acts as 1, above DEPTH acts as DEPTH);
// every capacity write also empties the queue. One item is worked at a time
// and s_tready is low while it is in flight; its result then waits in the
// output register, so the next item can be taken while the result is still
// pending. Enqueue goes straight to the done state; dequeue and peek pass
// a read state first unless empty; reversing the first k entries (capped
// at the fill count) swaps pairs, each as read, read, write, write through
// the one RAM write port and the shared slot adder. Entries are not cleared
// at reset and no clearing pass runs; only written entries are ever read.
module ring_queue_with_prefix_reverse_core
    import rqpr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_in, reverse_len, zero pad
    input  logic [OP_W-1:0]      s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // data_out, fill_count, zero pad
    output logic [ST_W-1:0]      m_tuser,   // status
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata
);

    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int PW       = AW + 1;
    localparam int CAP_INIT = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

    state_t              state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       cap_reg, cap_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [AW-1:0]       j_reg, j_next;
    op_t                 op_reg, op_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    status_t             res_status_reg, res_status_next;
    logic [DATA_W-1:0]   tmp_reg, tmp_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    status_t             out_status_reg, out_status_next;
    logic [FILL_W-1:0]   out_fill_reg, out_fill_next;

    op_t                 in_op;
    logic [DATA_W-1:0]   in_data;
    logic [LEN_W-1:0]    in_k;
    logic                accept;
    logic [CW-1:0]       k_eff;
    logic                out_free;
    logic                more_swaps;
    logic [31:0]         cap_wide;

    // shared slot unit: head + pos, wrapped at capacity
    logic [AW-1:0]       pos;
    logic [PW-1:0]       slot_sum;
    logic [PW-1:0]       slot_wrap;
    logic [AW-1:0]       slot_addr;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    assign in_op   = op_t'(s_tuser);
    assign in_data = s_tdata[DATA_W-1:0];
    assign in_k    = s_tdata[DATA_W+LEN_W-1:DATA_W];
    assign accept  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign slot_sum  = PW'(head_reg) + PW'(pos);
    assign slot_wrap = (slot_sum >= PW'(cap_reg)) ? (slot_sum - PW'(cap_reg)) : slot_sum;
    assign slot_addr = slot_wrap[AW-1:0];

    assign more_swaps = AW'(i_reg + 1'b1) < AW'(j_reg - 1'b1);

    always_comb
    begin
        if (32'(in_k) > 32'(count_reg))
        begin
            k_eff = count_reg;
        end
        else
        begin
            k_eff = CW'(in_k);
        end
    end

    rqpr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_ENQ:
                        begin
                            state_next = S_DONE;
                        end
                        OP_DEQ, OP_PEEK:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_READ;
                        end
                        OP_REV:
                        begin
                            state_next = (k_eff > CW'(1)) ? S_RD_A : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                state_next = S_WR_A;
            end
            S_WR_A:
            begin
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                state_next = more_swaps ? S_RD_A : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake, slot position, ram port
    always_comb
    begin
        s_tready  = 1'b0;
        pos       = '0;
        ram_we    = 1'b0;
        ram_wdata = in_data;
        ram_raddr = slot_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                pos       = count_reg[AW-1:0];
                ram_raddr = head_reg;
                ram_we    = accept && (in_op == OP_ENQ) && (count_reg < cap_reg);
            end
            S_READ:
            begin
                pos = AW'(1);
            end
            S_RD_A:
            begin
                pos = i_reg;
            end
            S_RD_B:
            begin
                pos = j_reg;
            end
            S_WR_A:
            begin
                pos       = i_reg;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            S_WR_B:
            begin
                pos       = j_reg;
                ram_we    = 1'b1;
                ram_wdata = tmp_reg;
            end
            S_DONE:
            begin
                pos = '0;
            end
            default:
            begin
                pos = '0;
            end
        endcase
    end

    assign ram_waddr = slot_addr;

    // datapath next values
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        op_next         = op_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        tmp_next        = tmp_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        cap_wide        = 32'(cfg_wdata);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = in_op;
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    i_next          = '0;
                    j_next          = AW'(k_eff - 1'b1);
                    if (in_op == OP_ENQ)
                    begin
                        if (count_reg < cap_reg)
                        begin
                            count_next = CW'(count_reg + 1'b1);
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    else if ((in_op == OP_DEQ || in_op == OP_PEEK) && count_reg == '0)
                    begin
                        res_data_next   = {DATA_W{1'b1}};
                        res_status_next = ST_EMPTY;
                    end
                end
            end
            S_READ:
            begin
                res_data_next = ram_rdata;
                if (op_reg == OP_DEQ)
                begin
                    head_next  = slot_addr;
                    count_next = CW'(count_reg - 1'b1);
                end
            end
            S_RD_B:
            begin
                tmp_next = ram_rdata;
            end
            S_WR_B:
            begin
                i_next = AW'(i_reg + 1'b1);
                j_next = AW'(j_reg - 1'b1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_status_next = res_status_reg;
                    out_fill_next   = FILL_W'(count_reg);
                end
            end
            default:
            begin
                tmp_next = tmp_reg;
            end
        endcase

        // capacity write empties the queue
        if (cfg_we)
        begin
            head_next  = '0;
            count_next = '0;
            if (cap_wide == 32'd0)
            begin
                cap_next = CW'(1);
            end
            else if (cap_wide > 32'(DEPTH))
            begin
                cap_next = CW'(DEPTH);
            end
            else
            begin
                cap_next = CW'(cap_wide);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CW'(CAP_INIT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        op_reg         <= op_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        tmp_reg        <= tmp_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-FILL_W){1'b0}}, out_fill_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule

@@ rtl/core/rqpr_ram.sv @@
module rqpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rqpr_checker.sv @@
`include "ring_queue_with_prefix_reverse_core_macros.svh"

module rqpr_checker
    import rqpr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,   // data_out, fill_count, zero pad
    input logic [ST_W-1:0]      m_tuser    // status
);

    logic                        in_xfer;
    logic                        out_stall;
    logic                        out_empty;
    logic                        out_full;
    logic [ST_W+M_TDATA_W-1:0]   out_word;
    logic [DATA_W-1:0]           out_data;
    logic [FILL_W-1:0]           out_fill;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign out_empty = m_tvalid && (m_tuser == ST_EMPTY);
    assign out_full  = m_tvalid && (m_tuser == ST_FULL);
    assign out_word  = {m_tuser, m_tdata};
    assign out_data  = m_tdata[DATA_W-1:0];
    assign out_fill  = m_tdata[DATA_W+FILL_W-1:DATA_W];

    // a stalled result holds
    `RQPR_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stall broken")

    // one item at a time: busy right after a transfer in
    `RQPR_ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_tready, "input taken while busy")

    // empty result carries all ones and an empty queue
    `RQPR_ASSERT_NOW(a_empty_result, out_empty, out_data == '1 && out_fill == '0, "bad empty")

    // full result: word dropped, queue not empty
    `RQPR_ASSERT_NOW(a_full_result, out_full, out_data == '0 && out_fill != '0, "bad full")

    // fill count never exceeds the built depth
    `RQPR_ASSERT_NOW(a_fill_range, m_tvalid, 32'(out_fill) <= 32'(DEPTH), "fill above depth")

endmodule

bind ring_queue_with_prefix_reverse_core rqpr_checker #(.DEPTH(DEPTH)) u_rqpr_checker (.*);

@@ bench/tb.sv @@
module tb;
    import rqpr_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        status_t           status;
        logic [FILL_W-1:0] fill;
    } queue_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;

    // predictor state
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    int                ring_head = 0;
    int                ring_fill = 0;
    logic [CAP_W-1:0]  ring_cap = CAP_W'(CAP_RESET);

    queue_result_t pending_results[$];

    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    bit hold_req = 1'b0;

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int full_drops = 0;
    int empty_reads = 0;
    int reversals = 0;
    int cap_writes = 0;
    int holds_done = 0;
    int peak_fill = 0;
    int quiet_cycles = 0;

    ring_queue_with_prefix_reverse_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int ring_limit();
        if (ring_cap == 0)
            return 1;
        if (ring_cap > RING_DEPTH)
            return RING_DEPTH;
        return ring_cap;
    endfunction

    function automatic int ring_slot(input int pos);
        int p;
        p = ring_head + pos;
        if (p >= ring_limit())
            p = p - ring_limit();
        if (p >= RING_DEPTH)
            p = 0;
        return p;
    endfunction

    function automatic queue_result_t predict_queue_op(input op_t op,
                                                       input logic [DATA_W-1:0] word,
                                                       input logic [LEN_W-1:0] k);
        queue_result_t res;
        logic [DATA_W-1:0] t;
        int span;
        int a;
        int b;
        res.data = '0;
        res.status = ST_OK;
        case (op)
            OP_ENQ:
            begin
                if (ring_fill >= ring_limit())
                begin
                    res.status = ST_FULL;
                    full_drops++;
                end
                else
                begin
                    ring_mem[ring_slot(ring_fill)] = word;
                    ring_fill++;
                end
            end
            OP_DEQ, OP_PEEK:
            begin
                if (ring_fill == 0)
                begin
                    res.data = '1;
                    res.status = ST_EMPTY;
                    empty_reads++;
                end
                else
                begin
                    res.data = ring_mem[ring_slot(0)];
                    if (op == OP_DEQ)
                    begin
                        ring_head = ring_slot(1);
                        ring_fill--;
                    end
                end
            end
            default:
            begin
                if (k > 1 && ring_fill != 0)
                begin
                    span = (k > ring_fill) ? ring_fill : k;
                    if (span > 1)
                        reversals++;
                    for (int i = 0; i < span / 2; i++)
                    begin
                        a = ring_slot(i);
                        b = ring_slot(span - 1 - i);
                        t = ring_mem[a];
                        ring_mem[a] = ring_mem[b];
                        ring_mem[b] = t;
                    end
                end
            end
        endcase
        if (ring_fill > peak_fill)
            peak_fill = ring_fill;
        res.fill = ring_fill[FILL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
    endtask

    // one input transfer; valid stays up after acceptance so a back-to-back item needs no toggle
    task automatic send_item(input op_t op, input logic [DATA_W-1:0] word,
                             input logic [LEN_W-1:0] k);
        int gap;
        gap = sender_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, k, word};
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        pending_results.push_back(predict_queue_op(op, word, k));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        ring_cap = value;
        ring_head = 0;
        ring_fill = 0;
        cap_writes++;
        cfg_we <= 1'b0;
    endtask

    // reset capacity, empty reads, word extremes, reverse lengths 0, 1, 2, 5 and beyond the fill
    task automatic test_directed_ops();
        send_item(OP_DEQ, 32'h1234_5678, 7'd0);
        send_item(OP_PEEK, 32'h0, 7'd0);
        send_item(OP_REV, 32'h0, 7'd4);
        send_item(OP_ENQ, 32'h7FFF_FFFF, 7'd0);
        send_item(OP_ENQ, 32'h8000_0000, 7'd0);
        send_item(OP_ENQ, 32'h0000_0000, 7'd0);
        send_item(OP_ENQ, 32'hFFFF_FFFF, 7'd0);
        send_item(OP_ENQ, 32'h0000_0001, 7'd0);
        send_item(OP_ENQ, 32'h5555_5555, 7'd0);
        send_item(OP_PEEK, 32'h0, 7'd0);
        send_item(OP_REV, 32'h0, 7'd0);
        send_item(OP_REV, 32'h0, 7'd1);
        send_item(OP_REV, 32'h0, 7'd2);
        send_item(OP_REV, 32'h0, 7'd5);
        send_item(OP_REV, 32'h0, 7'd127);
        send_item(OP_REV, 32'h0, 7'd64);
        send_item(OP_DEQ, 32'h0, 7'd0);
        send_item(OP_PEEK, 32'h0, 7'd0);
        send_item(OP_DEQ, 32'h0, 7'd0);
    endtask

    // zero capacity behaves as one entry, then capacity one itself
    task automatic test_tiny_capacity();
        write_capacity(7'd0);
        send_item(OP_ENQ, 32'hA5A5_A5A5, 7'd0);
        send_item(OP_ENQ, 32'h5A5A_5A5A, 7'd0);
        send_item(OP_PEEK, 32'h0, 7'd0);
        send_item(OP_REV, 32'h0, 7'd2);
        send_item(OP_DEQ, 32'h0, 7'd0);
        send_item(OP_DEQ, 32'h0, 7'd0);
        write_capacity(7'd1);
        send_item(OP_ENQ, 32'hC3C3_3C3C, 7'd0);
        send_item(OP_ENQ, 32'h0F0F_F0F0, 7'd0);
        send_item(OP_DEQ, 32'h0, 7'd0);
    endtask

    // fill and drain swings so the ring wraps and hits full and empty
    task automatic test_random_traffic(input logic [CAP_W-1:0] cap_value, input int n_items,
                                       input bit quiet);
        bit filling;
        int r;
        int top;
        op_t op;
        logic [DATA_W-1:0] word;
        logic [LEN_W-1:0] k;
        write_capacity(cap_value);
        sender_idle = !quiet;
        receiver_idle = !quiet;
        filling = 1'b1;
        repeat (n_items)
        begin
            if (ring_fill >= ring_limit())
                filling = 1'b0;
            else if (ring_fill == 0)
                filling = 1'b1;
            r = $urandom_range(0, 99);
            if (r < (filling ? 55 : 15))
                op = OP_ENQ;
            else if (r < 70)
                op = OP_DEQ;
            else if (r < 80)
                op = OP_PEEK;
            else
                op = OP_REV;
            r = $urandom_range(0, 9);
            if (r == 0)
                word = 32'h7FFF_FFFF;
            else if (r == 1)
                word = 32'h8000_0000;
            else
                word = $urandom();
            r = $urandom_range(0, 9);
            top = (ring_fill + 1 > 127) ? 127 : ring_fill + 1;
            if (r < 7)
                k = LEN_W'($urandom_range(0, top));
            else if (r < 9)
                k = LEN_W'($urandom_range(0, 127));
            else
                k = ring_fill[LEN_W-1:0];
            send_item(op, word, k);
        end
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // receiver holds off while items keep coming back to back
    task automatic test_output_stall();
        write_capacity(7'd64);
        sender_idle = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 6 == 5)
                send_item(OP_REV, 32'h0, 7'd9);
            else if (i % 4 == 3)
                send_item(OP_DEQ, 32'h0, 7'd0);
            else
                send_item(OP_ENQ, $urandom(), 7'd0);
        end
        sender_idle = 1'b1;
    endtask

    // result side: random stalls, long hold on request, check against oldest expectation
    initial
    begin
        queue_result_t got;
        queue_result_t want;
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
            begin
                gap = receiver_idle ? $urandom_range(0, 10) : 0;
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.data = m_tdata[DATA_W-1:0];
            got.fill = m_tdata[DATA_W +: FILL_W];
            got.status = status_t'(m_tuser);
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, data_out", got.data, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.data !== want.data)
                    report_mismatch("data_out", got.data, want.data);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.fill !== want.fill)
                    report_mismatch("fill_count", 32'(got.fill), 32'(want.fill));
            end
        end
    end

    // no transfer on either side for too long means the block hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles with no transfer", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_tiny_capacity();
        test_random_traffic(7'd1, 100, 1'b0);
        test_random_traffic(7'd127, 200, 1'b0);
        test_random_traffic(7'd0, 80, 1'b1);
        test_random_traffic(7'd64, 200, 1'b0);
        test_random_traffic(7'd2, 100, 1'b0);
        test_random_traffic(7'($urandom_range(3, 63)), 200, 1'b1);
        test_output_stall();
        test_random_traffic(7'($urandom_range(65, 126)), 200, 1'b0);
        settle();
        repeat (20) @(posedge clk);
        $display("ran %0d items and %0d transfers out over %0d capacity settings, peak fill %0d",
                 items_sent, results_seen, cap_writes, peak_fill);
        $display("saw %0d dropped enqueues, %0d empty reads, %0d real reversals, %0d long holds",
                 full_drops, empty_reads, reversals, holds_done);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
